>>> rtl/sorted_linked_list_manager_unit_assert.svh
// Assertion helpers for the list manager.
`ifndef SORTED_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH
`define SORTED_LINKED_LIST_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sllm_pkg.sv
package sllm_pkg;

  // Field widths of the two channels
  localparam int KIND_W     = 3;
  localparam int LIST_ID_W  = 3;
  localparam int NODE_ID_W  = 6;
  localparam int SORT_KEY_W = 32;
  localparam int STATUS_W   = 2;
  localparam int RES_LIST_W = 3;
  localparam int ITEM_CNT_W = 7;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INIT_LIST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INIT_NODE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SORTED    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ATTACHED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DETACHED = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [LIST_ID_W-1:0]  list_id;
    logic [NODE_ID_W-1:0]  node_id;
    logic [SORT_KEY_W-1:0] sort_key;
  } sllm_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [RES_LIST_W-1:0] result_list;
    logic [ITEM_CNT_W-1:0] item_count;
  } sllm_out_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_FETCH,
    S_SWP,
    S_DEC,
    S_GCNT,
    S_UNL,
    S_AT,
    S_AFT,
    S_WLK0,
    S_WLK,
    S_LNK1,
    S_LNK2,
    S_RESP
  } sllm_state_e;

endpackage

>>> rtl/sllm_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module sllm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and registered read (old data on a same-address collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sorted_linked_list_manager_unit.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | in_data_i  (sllm_in_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (sllm_out_t)
//
// One operation at a time. Init list sweeps the owner store.
// Sorted insert walks the list one link per cycle.
// After each operation the unit returns to idle before it takes the next.
// After reset a clearing pass over all link, owner, count and cursor entries runs before input is taken.
// A stalled result sits in the output register; the next operation is taken meanwhile.
`include "sorted_linked_list_manager_unit_assert.svh"

module sorted_linked_list_manager_unit
  import sllm_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int LIST_COUNT = 8,
  parameter int KEY_BITS   = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  sllm_in_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output sllm_out_t out_data_o,
  input  logic      out_stall_i
);

  localparam int SLOT_COUNT = NODE_COUNT + LIST_COUNT;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LIST_W     = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int OWN_W      = $clog2(LIST_COUNT + 1);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int IDX_W      = $clog2(SLOT_COUNT + 1);

  sllm_state_e state_q, state_d;

  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [KIND_W-1:0]   kind_q;
  logic [LIST_W-1:0]   l_q;
  logic [NODE_W-1:0]   n_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SLOT_W-1:0]   at_q, at_d;
  logic [SLOT_W-1:0]   after_q, after_d;
  logic [SLOT_W-1:0]   x_q, x_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [LIST_W-1:0]   res_list_q, res_list_d;
  logic [CNT_W-1:0]    res_cnt_q, res_cnt_d;
  logic                out_valid_q;
  sllm_out_t           out_q;
  logic                out_load;
  logic                in_fire;

  // Memory ports
  logic                nxt_we, prv_we, key_we, own_we, cnt_we, cur_we;
  logic [SLOT_W-1:0]   nxt_waddr, nxt_wdata, nxt_raddr, nxt_rd;
  logic [SLOT_W-1:0]   prv_waddr, prv_wdata, prv_raddr, prv_rd;
  logic [NODE_W-1:0]   key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_wdata, key_rd;
  logic [NODE_W-1:0]   own_waddr, own_raddr;
  logic [OWN_W-1:0]    own_wdata, own_rd;
  logic [LIST_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rd;
  logic [LIST_W-1:0]   cur_waddr, cur_raddr;
  logic [SLOT_W-1:0]   cur_wdata, cur_rd;

  // Derived indices
  logic [SLOT_W-1:0]   sent_slot, n_slot;
  logic [LIST_W-1:0]   own_lst;
  logic [OWN_W-1:0]    l_tag;
  logic [CNT_W-1:0]    cnt_inc, cnt_dec;

  // Index reduction tables for list_id and node_id
  logic [LIST_W-1:0] list_mod [2**LIST_ID_W];
  logic [NODE_W-1:0] node_mod [2**NODE_ID_W];

  for (genvar g = 0; g < 2**LIST_ID_W; g++) begin : g_list_mod
    assign list_mod[g] = LIST_W'(g % LIST_COUNT);
  end
  for (genvar g = 0; g < 2**NODE_ID_W; g++) begin : g_node_mod
    assign node_mod[g] = NODE_W'(g % NODE_COUNT);
  end

  assign in_fire   = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign sent_slot = SLOT_W'(NODE_COUNT) + SLOT_W'(l_q);
  assign n_slot    = SLOT_W'(n_q);
  assign own_lst   = LIST_W'(own_rd - OWN_W'(1));
  assign l_tag     = OWN_W'(l_q) + OWN_W'(1);
  assign cnt_inc   = cnt_rd + CNT_W'(1);
  assign cnt_dec   = (cnt_rd != '0) ? (cnt_rd - CNT_W'(1)) : '0;

  // Link, key, owner, count and cursor stores
  sllm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_nxt_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(nxt_raddr), .rdata_o(nxt_rd)
  );
  sllm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_prv_ram (
    .clk_i, .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .raddr_i(prv_raddr), .rdata_o(prv_rd)
  );
  sllm_ram #(.WIDTH(KEY_BITS), .DEPTH(NODE_COUNT)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_wdata),
    .raddr_i(key_raddr), .rdata_o(key_rd)
  );
  sllm_ram #(.WIDTH(OWN_W), .DEPTH(NODE_COUNT)) u_own_ram (
    .clk_i, .we_i(own_we), .waddr_i(own_waddr), .wdata_i(own_wdata),
    .raddr_i(own_raddr), .rdata_o(own_rd)
  );
  sllm_ram #(.WIDTH(CNT_W), .DEPTH(LIST_COUNT)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rd)
  );
  sllm_ram #(.WIDTH(SLOT_W), .DEPTH(LIST_COUNT)) u_cur_ram (
    .clk_i, .we_i(cur_we), .waddr_i(cur_waddr), .wdata_i(cur_wdata),
    .raddr_i(cur_raddr), .rdata_o(cur_rd)
  );

  // Sequencer: next state, memory controls and result capture
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    at_d         = at_q;
    after_d      = after_q;
    x_d          = x_q;
    res_status_d = res_status_q;
    res_list_d   = res_list_q;
    res_cnt_d    = res_cnt_q;
    out_load     = 1'b0;
    nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0; nxt_raddr = '0;
    prv_we = 1'b0; prv_waddr = '0; prv_wdata = '0; prv_raddr = '0;
    key_we = 1'b0; key_waddr = '0; key_wdata = '0; key_raddr = '0;
    own_we = 1'b0; own_waddr = '0; own_wdata = '0; own_raddr = '0;
    cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
    cur_we = 1'b0; cur_waddr = '0; cur_wdata = '0; cur_raddr = '0;

    case (state_q)
      // Post-reset pass: self links, owners detached, counts and cursors reset
      S_CLR: begin
        nxt_we    = 1'b1;
        nxt_waddr = SLOT_W'(idx_q);
        nxt_wdata = SLOT_W'(idx_q);
        prv_we    = 1'b1;
        prv_waddr = SLOT_W'(idx_q);
        prv_wdata = SLOT_W'(idx_q);
        if (idx_q < IDX_W'(NODE_COUNT)) begin
          own_we    = 1'b1;
          own_waddr = NODE_W'(idx_q);
        end
        if (idx_q < IDX_W'(LIST_COUNT)) begin
          cnt_we    = 1'b1;
          cnt_waddr = LIST_W'(idx_q);
          cur_we    = 1'b1;
          cur_waddr = LIST_W'(idx_q);
          cur_wdata = SLOT_W'(NODE_COUNT) + SLOT_W'(idx_q);
        end
        if (idx_q == IDX_W'(SLOT_COUNT - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          state_d = S_FETCH;
        end
      end

      // First reads; init list resets the list head here
      S_FETCH: begin
        own_raddr    = n_q;
        cnt_raddr    = l_q;
        cur_raddr    = l_q;
        prv_raddr    = sent_slot;
        res_list_d   = l_q;
        res_status_d = STAT_OK;
        if (kind_q == KIND_INIT_LIST) begin
          nxt_we    = 1'b1;
          nxt_waddr = sent_slot;
          nxt_wdata = sent_slot;
          prv_we    = 1'b1;
          prv_waddr = sent_slot;
          prv_wdata = sent_slot;
          cnt_we    = 1'b1;
          cnt_waddr = l_q;
          cur_we    = 1'b1;
          cur_waddr = l_q;
          cur_wdata = sent_slot;
          res_cnt_d = '0;
          idx_d     = '0;
          state_d   = S_SWP;
        end else begin
          state_d = S_DEC;
        end
      end

      // Sweep the owner store, detaching every node of the list
      S_SWP: begin
        own_raddr = NODE_W'(idx_q);
        if ((idx_q != '0) && (own_rd == l_tag)) begin
          own_we    = 1'b1;
          own_waddr = NODE_W'(idx_q - IDX_W'(1));
        end
        if (idx_q == IDX_W'(NODE_COUNT)) begin
          idx_d   = '0;
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // Decode on owner, count and cursor of the target
      S_DEC: begin
        res_cnt_d = cnt_rd;
        case (kind_q)
          KIND_INIT_NODE, KIND_REMOVE: begin
            if (own_rd == '0) begin
              res_status_d = (kind_q == KIND_REMOVE) ? STAT_DETACHED : STAT_OK;
              state_d      = S_RESP;
            end else begin
              res_list_d = own_lst;
              own_we     = 1'b1;
              own_waddr  = n_q;
              prv_raddr  = n_slot;
              nxt_raddr  = n_slot;
              cnt_raddr  = own_lst;
              cur_raddr  = own_lst;
              state_d    = S_UNL;
            end
          end
          KIND_APPEND, KIND_SORTED: begin
            if (own_rd != '0) begin
              res_status_d = STAT_ATTACHED;
              res_list_d   = own_lst;
              cnt_raddr    = own_lst;
              state_d      = S_GCNT;
            end else begin
              key_we    = 1'b1;
              key_waddr = n_q;
              key_wdata = key_q;
              own_we    = 1'b1;
              own_waddr = n_q;
              own_wdata = l_tag;
              cnt_we    = 1'b1;
              cnt_waddr = l_q;
              cnt_wdata = cnt_inc;
              res_cnt_d = cnt_inc;
              if (kind_q == KIND_APPEND) begin
                prv_raddr = cur_rd;
                state_d   = S_AT;
              end else if (key_q == '1) begin
                // tail key: link after the last node
                at_d      = prv_rd;
                nxt_raddr = prv_rd;
                state_d   = S_AFT;
              end else begin
                at_d      = sent_slot;
                nxt_raddr = sent_slot;
                state_d   = S_WLK0;
              end
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // Count of the list holding an attached node
      S_GCNT: begin
        res_cnt_d = cnt_rd;
        state_d   = S_RESP;
      end

      // Unlink: bridge neighbours, pull cursor back if it is on the node, decrement count
      S_UNL: begin
        nxt_we    = 1'b1;
        nxt_waddr = prv_rd;
        nxt_wdata = nxt_rd;
        prv_we    = 1'b1;
        prv_waddr = nxt_rd;
        prv_wdata = prv_rd;
        if (cur_rd == n_slot) begin
          cur_we    = 1'b1;
          cur_waddr = res_list_q;
          cur_wdata = prv_rd;
        end
        cnt_we    = 1'b1;
        cnt_waddr = res_list_q;
        cnt_wdata = cnt_dec;
        res_cnt_d = cnt_dec;
        state_d   = S_RESP;
      end

      // Append: insertion point is the link before the cursor
      S_AT: begin
        at_d      = prv_rd;
        nxt_raddr = prv_rd;
        state_d   = S_AFT;
      end

      S_AFT: begin
        after_d = nxt_rd;
        state_d = S_LNK1;
      end

      // Walk start: first link after the sentinel
      S_WLK0: begin
        x_d       = nxt_rd;
        key_raddr = NODE_W'(nxt_rd);
        nxt_raddr = nxt_rd;
        state_d   = S_WLK;
      end

      // Walk: one link per cycle while the next key is not above ours
      S_WLK: begin
        if ((x_q < SLOT_W'(NODE_COUNT)) && (key_rd <= key_q)) begin
          at_d      = x_q;
          x_d       = nxt_rd;
          key_raddr = NODE_W'(nxt_rd);
          nxt_raddr = nxt_rd;
        end else begin
          after_d = x_q;
          state_d = S_LNK1;
        end
      end

      // Link the node between at and after
      S_LNK1: begin
        nxt_we    = 1'b1;
        nxt_waddr = n_slot;
        nxt_wdata = after_q;
        prv_we    = 1'b1;
        prv_waddr = after_q;
        prv_wdata = n_slot;
        state_d   = S_LNK2;
      end

      S_LNK2: begin
        prv_we    = 1'b1;
        prv_waddr = n_slot;
        prv_wdata = at_q;
        nxt_we    = 1'b1;
        nxt_waddr = at_q;
        nxt_wdata = n_slot;
        state_d   = S_RESP;
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_data_i.kind;
      l_q    <= list_mod[in_data_i.list_id];
      n_q    <= node_mod[in_data_i.node_id];
      key_q  <= KEY_BITS'(in_data_i.sort_key);
    end
    at_q         <= at_d;
    after_q      <= after_d;
    x_q          <= x_d;
    res_status_q <= res_status_d;
    res_list_q   <= res_list_d;
    res_cnt_q    <= res_cnt_d;
    if (out_load) begin
      out_q.status      <= res_status_q;
      out_q.result_list <= RES_LIST_W'(res_list_q);
      out_q.item_count  <= ITEM_CNT_W'(res_cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `SLLM_ASSERT_IMP(a_walk_skips_new_node, state_q == S_WLK, x_q != n_slot,
                   "walk reached the node being inserted")
  `SLLM_ASSERT_NXT(a_resp_waits, (state_q == S_RESP) && out_valid_q && out_stall_i,
                   state_q == S_RESP, "result dropped while output stalled")
  `SLLM_ASSERT_IMP(a_clr_bound, state_q == S_CLR, idx_q < IDX_W'(SLOT_COUNT),
                   "clearing pass ran past the link store")

endmodule
